FILE: rtl/advertising_report_filter_defines.svh
// assertion macros shared by the parser and top-level rtl files
`ifndef ADVERTISING_REPORT_FILTER_DEFINES_SVH
`define ADVERTISING_REPORT_FILTER_DEFINES_SVH

`ifndef SYNTHESIS
// checked on every rising edge, skipped while reset is high
`define AFR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every rising edge, reset included
`define AFR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AFR_ASSERT(label, clk, rst, prop, msg)
`define AFR_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

FILE: rtl/afr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package afr_pkg;

   localparam int unsigned MAX_NAME_BYTES_DEFAULT = 29;
   localparam int unsigned ADDR_W                 = 48;
   localparam int unsigned ADDR_BYTES             = 6;
   localparam int unsigned CSR_IDX_W              = 3;
   localparam int unsigned CSR_DATA_W             = 64;
   localparam int unsigned REQ_DATA_W             = 56;
   localparam int unsigned REQ_USER_W             = 2;
   localparam int unsigned RSP_DATA_W             = 8;

   localparam logic [7:0] TYPE_SHORT_NAME = 8'h08;
   localparam logic [7:0] TYPE_FULL_NAME  = 8'h09;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ADDRESS_FILTER,
      CSR_ADDRESS_FILTER_LENGTH,
      CSR_NAME_LENGTH,
      CSR_NAME_BYTES_0_7,
      CSR_NAME_BYTES_8_15,
      CSR_NAME_BYTES_16_23,
      CSR_NAME_BYTES_24_28
   } csr_index_type;

   typedef struct packed {
      logic [ADDR_W-1:0] address_filter;
      logic [2:0]        address_filter_length;
      logic [4:0]        name_length;
   } cfg_type;

   typedef struct packed {
      logic [ADDR_W-1:0] report_address;
      logic [7:0]        data_byte;
      logic              has_data;
      logic              first_byte;
      logic              last_byte;
   } req_item_type;

   typedef struct packed {
      logic address_match;
      logic name_match;
      logic accept;
   } verdict_type;

endpackage

`default_nettype wire

FILE: rtl/afr_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module afr_csr #(
   parameter int unsigned MAX_NAME_BYTES = afr_pkg::MAX_NAME_BYTES_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [afr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [afr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output afr_pkg::cfg_type                     cfg,
   output logic [7:0]                           name_bytes [MAX_NAME_BYTES]
);
   import afr_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ADDRESS_FILTER:        cfg_ff.address_filter        <= csr_wdata[ADDR_W-1:0];
            CSR_ADDRESS_FILTER_LENGTH: cfg_ff.address_filter_length <= csr_wdata[2:0];
            CSR_NAME_LENGTH:           cfg_ff.name_length           <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

   // byte g sits in name register g/8, lane g%8
   for (genvar g = 0; g < MAX_NAME_BYTES; g++) begin : g_name
      localparam int unsigned REG_IDX = int'(CSR_NAME_BYTES_0_7) + g / 8;
      localparam int unsigned LANE    = (g % 8) * 8;
      logic [7:0] name_ff;

      always_ff @(posedge clock) begin
         if (reset) begin
            name_ff <= '0;
         end else if (csr_we && csr_index == CSR_IDX_W'(REG_IDX)) begin
            name_ff <= csr_wdata[LANE +: 8];
         end
      end

      assign name_bytes[g] = name_ff;
   end

endmodule

`default_nettype wire

FILE: rtl/afr_parser.sv
`timescale 1ns / 1ps
`default_nettype none

`include "advertising_report_filter_defines.svh"

module afr_parser #(
   parameter int unsigned MAX_NAME_BYTES = afr_pkg::MAX_NAME_BYTES_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  afr_pkg::req_item_type     item,
   input  afr_pkg::cfg_type          cfg,
   input  wire logic [7:0]           name_bytes [MAX_NAME_BYTES],
   output logic                      emit,
   output afr_pkg::verdict_type      verdict
);
   import afr_pkg::*;

   localparam int unsigned IDX_W = (MAX_NAME_BYTES > 1) ? $clog2(MAX_NAME_BYTES) : 1;

   logic [7:0] record_offset_ff, record_offset_in;
   logic [7:0] record_length_ff, record_length_in;
   logic [7:0] record_type_ff,   record_type_in;
   logic       bytes_equal_ff,   bytes_equal_in;
   logic       parse_stopped_ff, parse_stopped_in;
   logic       name_found_ff,    name_found_in;
   logic       address_ok_ff,    address_ok_in;

   logic       addr_pass;
   logic [2:0] prefix_bytes;

   always_comb begin
      prefix_bytes = (cfg.address_filter_length > 3'd6) ? 3'd6 : cfg.address_filter_length;
      addr_pass    = 1'b1;
      for (int i = 0; i < ADDR_BYTES; i++) begin
         if (3'(i) < prefix_bytes &&
             item.report_address[i*8 +: 8] != cfg.address_filter[i*8 +: 8]) begin
            addr_pass = 1'b0;
         end
      end
   end

   always_comb begin
      logic             start;
      logic             last;
      logic [7:0]       k;
      logic [IDX_W-1:0] k_idx;
      logic [7:0]       b;

      start = !item.has_data || item.first_byte;
      last  = !item.has_data || item.last_byte;
      b     = item.data_byte;
      k     = record_offset_ff - 8'd2;
      k_idx = k[IDX_W-1:0];

      if (start) begin
         record_offset_in = '0;
         record_length_in = '0;
         record_type_in   = '0;
         bytes_equal_in   = 1'b1;
         parse_stopped_in = 1'b0;
         name_found_in    = 1'b0;
         address_ok_in    = addr_pass;
      end else begin
         record_offset_in = record_offset_ff;
         record_length_in = record_length_ff;
         record_type_in   = record_type_ff;
         bytes_equal_in   = bytes_equal_ff;
         parse_stopped_in = parse_stopped_ff;
         name_found_in    = name_found_ff;
         address_ok_in    = address_ok_ff;
      end

      if (!item.has_data) begin
         parse_stopped_in = 1'b1;
      end else if (!parse_stopped_in) begin
         if (record_offset_in == 8'd0) begin
            // length byte of a new record
            if (b == 8'd0) begin
               parse_stopped_in = 1'b1;
            end else begin
               record_length_in = b;
               bytes_equal_in   = 1'b1;
               record_offset_in = 8'd1;
            end
         end else begin
            if (record_offset_in == 8'd1) begin
               record_type_in = b;
            end else if (k < {3'b000, cfg.name_length} && k < 8'(MAX_NAME_BYTES) &&
                         b != name_bytes[k_idx]) begin
               bytes_equal_in = 1'b0;
            end
            if (record_offset_in == record_length_in) begin
               if ((record_type_in == TYPE_SHORT_NAME || record_type_in == TYPE_FULL_NAME) &&
                   cfg.name_length != 5'd0 && cfg.name_length <= 5'(MAX_NAME_BYTES) &&
                   record_length_in == {3'b000, cfg.name_length} + 8'd1 &&
                   bytes_equal_in) begin
                  name_found_in    = 1'b1;
                  parse_stopped_in = 1'b1;
               end
               record_offset_in = 8'd0;
            end else begin
               record_offset_in = record_offset_in + 8'd1;
            end
         end
      end

      if (last) begin
         parse_stopped_in = 1'b1;
      end
      emit = last;
   end

   assign verdict.address_match = address_ok_in;
   assign verdict.name_match    = name_found_in;
   assign verdict.accept        = address_ok_in && name_found_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         record_offset_ff <= '0;
         record_length_ff <= '0;
         record_type_ff   <= '0;
         bytes_equal_ff   <= 1'b1;
         parse_stopped_ff <= 1'b0;
         name_found_ff    <= 1'b0;
         address_ok_ff    <= 1'b0;
      end else if (step) begin
         record_offset_ff <= record_offset_in;
         record_length_ff <= record_length_in;
         record_type_ff   <= record_type_in;
         bytes_equal_ff   <= bytes_equal_in;
         parse_stopped_ff <= parse_stopped_in;
         name_found_ff    <= name_found_in;
         address_ok_ff    <= address_ok_in;
      end
   end

   `AFR_ASSERT(a_found_stops, clock, reset, name_found_ff |-> parse_stopped_ff, "name found but parse still running")
   `AFR_ASSERT(a_offset_in_record, clock, reset, record_offset_ff != 8'd0 |-> record_offset_ff <= record_length_ff, "record offset past record length")

endmodule

`default_nettype wire

FILE: rtl/advertising_report_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// advertising report filter, one data byte per transaction
// the last byte is held in the request register and its verdict in the result register, which drives rsp_
// throughput: one byte per cycle while rsp_tready does not stall the result register, set by the single
//   parse step between the request register and the result register
// reset: synchronous active high; empties both pipeline stages, clears all
//   configuration registers and puts the parse state idle (name compare flag set)

`include "advertising_report_filter_defines.svh"

module advertising_report_filter #(
   parameter int unsigned MAX_NAME_BYTES = afr_pkg::MAX_NAME_BYTES_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request stream
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [afr_pkg::REQ_DATA_W-1:0]    req_tdata,  // report_address, data_byte
   input  wire logic [afr_pkg::REQ_USER_W-1:0]    req_tuser,  // has_data, first_byte
   input  wire logic                              req_tlast,  // last_byte
   // response stream
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [afr_pkg::RSP_DATA_W-1:0]         rsp_tdata,  // address_match, name_match, accept, zero pad
   // configuration writes
   input  wire logic                              csr_we,
   input  wire logic [afr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [afr_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import afr_pkg::*;

   cfg_type      cfg;
   logic [7:0]   name_bytes [MAX_NAME_BYTES];

   // request register
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         req_fire;
   logic         advance;

   // result register
   logic         out_valid_ff, out_valid_in;
   verdict_type  out_verdict_ff;

   logic         emit;
   verdict_type  verdict;

   afr_csr #(
      .MAX_NAME_BYTES (MAX_NAME_BYTES)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cfg        (cfg),
      .name_bytes (name_bytes)
   );

   // the held byte is parsed when the result register can take its verdict
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.report_address <= req_tdata[ADDR_W-1:0];
         in_item_ff.data_byte      <= req_tdata[ADDR_W +: 8];
         in_item_ff.has_data       <= req_tuser[0];
         in_item_ff.first_byte     <= req_tuser[1];
         in_item_ff.last_byte      <= req_tlast;
      end
   end

   afr_parser #(
      .MAX_NAME_BYTES (MAX_NAME_BYTES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .item       (in_item_ff),
      .cfg        (cfg),
      .name_bytes (name_bytes),
      .emit       (emit),
      .verdict    (verdict)
   );

   // a verdict is loaded only on the last byte of a report, or on an item without data
   always_comb begin
      if (advance && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         out_verdict_ff <= verdict;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b00000, out_verdict_ff.accept, out_verdict_ff.name_match,
                        out_verdict_ff.address_match};

   `AFR_ASSERT(a_stall_blocks_req, clock, reset, (in_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready, "request taken while both stages are blocked")
   `AFR_ASSERT(a_empty_report_emits, clock, reset, (advance && !in_item_ff.has_data) |=> rsp_tvalid, "report without data gave no verdict")
   `AFR_ASSERT(a_accept_is_and, clock, reset, rsp_tvalid |-> (rsp_tdata[2] == (rsp_tdata[0] && rsp_tdata[1])), "accept differs from address and name match")

endmodule

`default_nettype wire
